[rtl/mud_pkg.sv]
// ----------------------------------------------------------------------------
// mud_pkg
// Shared types and codes for the multi-encoding character decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mud_pkg;

	// encoding selector codes
	typedef enum logic [2:0] {
		ENC_ASCII_EXT = 3'd0,
		ENC_UTF8      = 3'd1,
		ENC_UTF16_LE  = 3'd2,
		ENC_UTF16_BE  = 3'd3,
		ENC_UTF32_LE  = 3'd4,
		ENC_UTF32_BE  = 3'd5
	} mud_enc_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_CHAR       = 3'd0,
		ST_TERM       = 3'd1,
		ST_INCOMPLETE = 3'd2,
		ST_ILLEGAL    = 3'd3,
		ST_RESTART    = 3'd4
	} mud_status_t;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_ENCODING_SELECT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_IS_16BIT   = 2'd1;

	localparam logic [2:0] ENC_RESET = 3'd1;

	// surrogate ranges
	localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
	localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
	localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
	localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
	localparam logic [5:0]  HI_SURR_TAG   = 6'b110110;
	localparam logic [5:0]  LO_SURR_TAG   = 6'b110111;
	localparam logic [31:0] MAX_CODE      = 32'h0010FFFF;

	// input word
	typedef struct packed {
		logic       restart;
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic [7:0] third_byte;
		logic [7:0] fourth_byte;
		logic [2:0] bytes_available;
	} mud_in_t;

	// result word
	typedef struct packed {
		logic [31:0] wide_char;
		logic [2:0]  bytes_used;
		logic [2:0]  status;
		logic        in_initial_state;
	} mud_out_t;

endpackage

`default_nettype wire

[rtl/mud_if.sv]
// ----------------------------------------------------------------------------
// mud_in_if / mud_out_if
// Valid/ready channels carrying the decoder input and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mud_in_if import mud_pkg::*; ();
	logic    valid;
	logic    ready;
	mud_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mud_out_if import mud_pkg::*; ();
	logic     valid;
	logic     ready;
	mud_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/multi_encoding_unicode_decoder.sv]
// ----------------------------------------------------------------------------
// multi_encoding_unicode_decoder
// Decodes one character per word from a four-byte window (extended ASCII,
// UTF-8, UTF-16 LE/BE, UTF-32 LE/BE), with optional surrogate splitting.
// ----------------------------------------------------------------------------
//  channel  dir  protocol      payload
//  din      in   valid/ready   restart, four window bytes, bytes_available
//  dout     out  valid/ready   wide_char, bytes_used, status, in_initial_state
//  cfg      in   write only    cfg_we, cfg_index, cfg_wdata
//
//  Results come from the result register; one word per cycle is sustained
//  unless the output stalls. Decode sits between the input register and the
//  result register; the pending low surrogate updates as a word leaves the
//  input register. Reset clears both valid flags and the pending surrogate
//  and sets UTF-8 without splitting. A stalled result holds; one more word
//  is still taken into the input register while the result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_encoding_unicode_decoder import mud_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mud_in_if.sink                     din,
	mud_out_if.source                  dout,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [2:0]  enc_q;
	logic        wide16_q;
	logic [15:0] pend_q;

	logic        v_s1;
	mud_in_t     in_s1;
	logic        v_s2;
	mud_out_t    res_s2;

	logic        adv1;
	logic        acc_in;

	logic [2:0]  n;
	logic [15:0] u1;
	logic [15:0] u2;
	logic [31:0] base_cp;
	logic [2:0]  base_used;
	mud_status_t base_st;
	logic [20:0] adj;
	logic [31:0] res_cp;
	logic [2:0]  res_used;
	mud_status_t res_st;
	logic [15:0] pend_d;

	// handshake
	assign adv1       = !v_s2 || dout.ready;
	assign din.ready  = !v_s1 || adv1;
	assign acc_in     = din.valid && din.ready;
	assign dout.valid = v_s2;
	assign dout.data  = res_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q    <= ENC_RESET;
			wide16_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ENCODING_SELECT) begin
				enc_q <= cfg_wdata;
			end else if (cfg_index == CFG_WIDE_IS_16BIT) begin
				wide16_q <= cfg_wdata[0];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (din.ready) begin
			v_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			in_s1 <= din.data;
		end
	end

	// window decode into a base code point
	always_comb begin
		n = (in_s1.bytes_available > 3'd4) ? 3'd4 : in_s1.bytes_available;
		if (enc_q == ENC_UTF16_BE) begin
			u1 = {in_s1.first_byte, in_s1.second_byte};
			u2 = {in_s1.third_byte, in_s1.fourth_byte};
		end else begin
			u1 = {in_s1.second_byte, in_s1.first_byte};
			u2 = {in_s1.fourth_byte, in_s1.third_byte};
		end
		base_cp   = '0;
		base_used = '0;
		base_st   = ST_CHAR;
		if (n == 3'd0) begin
			base_st = ST_INCOMPLETE;
		end else begin
			case (enc_q)
				ENC_UTF8: begin
					if (in_s1.first_byte == 8'h00) begin
						base_st = ST_TERM;
					end else if (!in_s1.first_byte[7]) begin
						base_cp   = {24'd0, in_s1.first_byte};
						base_used = 3'd1;
					end else if (in_s1.first_byte[7:5] == 3'b110) begin
						if (n < 3'd2) begin
							base_st = ST_INCOMPLETE;
						end else begin
							base_cp   = {21'd0, in_s1.first_byte[4:0],
								in_s1.second_byte[5:0]};
							base_used = 3'd2;
						end
					end else if (in_s1.first_byte[7:4] == 4'b1110) begin
						if (n < 3'd3) begin
							base_st = ST_INCOMPLETE;
						end else begin
							base_cp   = {16'd0, in_s1.first_byte[3:0],
								in_s1.second_byte[5:0], in_s1.third_byte[5:0]};
							base_used = 3'd3;
						end
					end else if (in_s1.first_byte[7:3] == 5'b11110) begin
						if (n < 3'd4) begin
							base_st = ST_INCOMPLETE;
						end else begin
							base_cp   = {11'd0, in_s1.first_byte[2:0],
								in_s1.second_byte[5:0], in_s1.third_byte[5:0],
								in_s1.fourth_byte[5:0]};
							base_used = 3'd4;
						end
					end else begin
						base_st = ST_ILLEGAL;
					end
				end
				ENC_UTF16_LE, ENC_UTF16_BE: begin
					if (n < 3'd2) begin
						base_st = ST_INCOMPLETE;
					end else if (u1 == 16'h0000) begin
						base_st = ST_TERM;
					end else if (u1 >= HI_SURR_FIRST && u1 <= HI_SURR_LAST) begin
						if (n < 3'd4) begin
							base_st = ST_INCOMPLETE;
						end else if (u2 < LO_SURR_FIRST || u2 > LO_SURR_LAST) begin
							base_st = ST_ILLEGAL;
						end else begin
							// add 0x10000 to the joined 20-bit value
							base_cp   = {11'd0, {1'b0, u1[9:6]} + 5'd1,
								u1[5:0], u2[9:0]};
							base_used = 3'd4;
						end
					end else begin
						base_cp   = {16'd0, u1};
						base_used = 3'd2;
					end
				end
				ENC_UTF32_LE, ENC_UTF32_BE: begin
					if (n < 3'd4) begin
						base_st = ST_INCOMPLETE;
					end else begin
						if (enc_q == ENC_UTF32_BE) begin
							base_cp = {in_s1.first_byte, in_s1.second_byte,
								in_s1.third_byte, in_s1.fourth_byte};
						end else begin
							base_cp = {in_s1.fourth_byte, in_s1.third_byte,
								in_s1.second_byte, in_s1.first_byte};
						end
						if (base_cp == 32'd0) begin
							base_st = ST_TERM;
						end else begin
							base_used = 3'd4;
						end
					end
				end
				default: begin
					// extended ascii, also for unused selector codes
					if (in_s1.first_byte == 8'h00) begin
						base_st = ST_TERM;
					end else begin
						base_cp   = {24'd0, in_s1.first_byte};
						base_used = 3'd1;
					end
				end
			endcase
		end
	end

	// restart, pending surrogate and surrogate split
	always_comb begin
		adj      = base_cp[20:0] - 21'h10000;
		res_cp   = base_cp;
		res_used = base_used;
		res_st   = base_st;
		pend_d   = pend_q;
		if (in_s1.restart) begin
			res_cp   = '0;
			res_used = '0;
			res_st   = ST_RESTART;
			pend_d   = '0;
		end else if (pend_q != 16'd0) begin
			res_cp   = {16'd0, pend_q};
			res_used = '0;
			res_st   = ST_CHAR;
			pend_d   = '0;
		end else if (base_st != ST_CHAR) begin
			res_cp   = '0;
			res_used = '0;
		end else if (wide16_q && base_cp[31:16] != 16'd0) begin
			if (base_cp > MAX_CODE) begin
				res_cp   = '0;
				res_used = '0;
				res_st   = ST_ILLEGAL;
			end else begin
				res_cp = {16'd0, HI_SURR_TAG, adj[19:10]};
				pend_d = {LO_SURR_TAG, adj[9:0]};
			end
		end
	end

	// result register and pending surrogate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			pend_q <= '0;
		end else if (adv1) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				pend_q <= pend_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && v_s1) begin
			res_s2.wide_char        <= res_cp;
			res_s2.bytes_used       <= res_used;
			res_s2.status           <= res_st;
			res_s2.in_initial_state <= (pend_d == 16'd0);
		end
	end

`ifndef NO_ASSERTIONS
	// anything but a character carries no code point and no bytes
	a_nonchar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && res_s2.status != ST_CHAR |->
			res_s2.wide_char == 32'd0 && res_s2.bytes_used == 3'd0)
		else $error("non-character result with payload");

	// a stored surrogate is always a low surrogate
	a_pend_low: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 16'd0 |-> pend_q[15:10] == LO_SURR_TAG)
		else $error("pending value is not a low surrogate");

	// a pending surrogate is drained by the next decoded word
	a_pend_drain: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && v_s1 && pend_q != 16'd0 |=>
			pend_q == 16'd0 && res_s2.bytes_used == 3'd0 && res_s2.in_initial_state)
		else $error("pending surrogate not returned");

	// input is held back only when both stages are full and the output stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> v_s1 && v_s2 && !dout.ready)
		else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-encoding character decoder: a directed
// pass over the selector codes and corner cases, then random windows under
// every selector and wide-mode setting, with random idling on both channels,
// a long output stall and an input pause. Every result word is checked field
// by field against a behavioral decoder kept in the scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import mud_pkg::*; ();

	localparam int         CYCLE_LIMIT   = 400000;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         PHASE_WORDS   = 102;
	localparam int         MAX_MSG_LINES = 30;
	localparam logic [2:0] ENC_SPARE     = 3'd7;

	typedef enum logic [1:0] {
		RX_RANDOM,
		RX_STEADY,
		RX_HOLD
	} rx_mode_t;

	// --------------------------------------------------------------------
	// scoreboard: decoder prediction and in-order result checking
	// --------------------------------------------------------------------
	class decode_scoreboard;
		logic [2:0]  enc_sel = ENC_RESET;
		logic        wide16  = 1'b0;
		logic [15:0] pending_lo = 16'h0;
		mud_out_t    expected_chars[$];
		int          errors = 0;
		int          checked = 0;
		int          status_seen[5] = '{default: 0};

		function void set_config(logic [2:0] enc, logic wide);
			enc_sel = enc;
			wide16  = wide;
		endfunction

		function int outstanding();
			return expected_chars.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_MSG_LINES)
				$display("mismatch: %s", msg);
		endtask

		function mud_out_t result_of(logic [31:0] wc, logic [2:0] used, mud_status_t st);
			mud_out_t r;
			r.wide_char        = wc;
			r.bytes_used       = used;
			r.status           = st;
			r.in_initial_state = (pending_lo == 16'h0);
			return r;
		endfunction

		// one step of the decoder: returns the result and updates the pending half
		function mud_out_t decode_window(mud_in_t w);
			logic [7:0]  b0;
			logic [7:0]  b1;
			logic [7:0]  b2;
			logic [7:0]  b3;
			logic [2:0]  n;
			logic [15:0] u1;
			logic [15:0] u2;
			logic [31:0] cp;
			logic [31:0] adj;
			logic [2:0]  used;
			b0 = w.first_byte;
			b1 = w.second_byte;
			b2 = w.third_byte;
			b3 = w.fourth_byte;
			cp = 32'h0;
			used = 3'd0;

			// restart and a held low surrogate ignore the window
			if (w.restart) begin
				pending_lo = 16'h0;
				return result_of(32'h0, 3'd0, ST_RESTART);
			end
			if (pending_lo != 16'h0) begin
				cp = {16'h0, pending_lo};
				pending_lo = 16'h0;
				return result_of(cp, 3'd0, ST_CHAR);
			end
			n = (w.bytes_available > 3'd4) ? 3'd4 : w.bytes_available;
			if (n == 3'd0)
				return result_of(32'h0, 3'd0, ST_INCOMPLETE);

			case (enc_sel)
				ENC_UTF8: begin
					if (b0 == 8'h00)
						return result_of(32'h0, 3'd0, ST_TERM);
					if (b0 <= 8'h7F) begin
						cp = {24'h0, b0};
						used = 3'd1;
					end else if ((b0 & 8'hE0) == 8'hC0) begin
						if (n < 3'd2)
							return result_of(32'h0, 3'd0, ST_INCOMPLETE);
						cp = {21'h0, b0[4:0], b1[5:0]};
						used = 3'd2;
					end else if ((b0 & 8'hF0) == 8'hE0) begin
						if (n < 3'd3)
							return result_of(32'h0, 3'd0, ST_INCOMPLETE);
						cp = {16'h0, b0[3:0], b1[5:0], b2[5:0]};
						used = 3'd3;
					end else if ((b0 & 8'hF8) == 8'hF0) begin
						if (n < 3'd4)
							return result_of(32'h0, 3'd0, ST_INCOMPLETE);
						cp = {11'h0, b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
						used = 3'd4;
					end else begin
						return result_of(32'h0, 3'd0, ST_ILLEGAL);
					end
				end
				ENC_UTF16_LE, ENC_UTF16_BE: begin
					if (n < 3'd2)
						return result_of(32'h0, 3'd0, ST_INCOMPLETE);
					u1 = (enc_sel == ENC_UTF16_BE) ? {b0, b1} : {b1, b0};
					if (u1 == 16'h0)
						return result_of(32'h0, 3'd0, ST_TERM);
					if (u1 >= HI_SURR_FIRST && u1 <= HI_SURR_LAST) begin
						if (n < 3'd4)
							return result_of(32'h0, 3'd0, ST_INCOMPLETE);
						u2 = (enc_sel == ENC_UTF16_BE) ? {b2, b3} : {b3, b2};
						if (u2 < LO_SURR_FIRST || u2 > LO_SURR_LAST)
							return result_of(32'h0, 3'd0, ST_ILLEGAL);
						cp = 32'h10000 + {12'h0, u1[9:0], u2[9:0]};
						used = 3'd4;
					end else begin
						// lone low surrogates pass straight through
						cp = {16'h0, u1};
						used = 3'd2;
					end
				end
				ENC_UTF32_LE, ENC_UTF32_BE: begin
					if (n < 3'd4)
						return result_of(32'h0, 3'd0, ST_INCOMPLETE);
					cp = (enc_sel == ENC_UTF32_BE) ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
					if (cp == 32'h0)
						return result_of(32'h0, 3'd0, ST_TERM);
					used = 3'd4;
				end
				default: begin
					// extended ascii, also the two spare selector codes
					if (b0 == 8'h00)
						return result_of(32'h0, 3'd0, ST_TERM);
					cp = {24'h0, b0};
					used = 3'd1;
				end
			endcase

			// surrogate split in 16-bit wide mode
			if (wide16 && cp >= 32'h10000) begin
				if (cp > MAX_CODE)
					return result_of(32'h0, 3'd0, ST_ILLEGAL);
				adj = cp - 32'h10000;
				pending_lo = LO_SURR_FIRST + {6'h0, adj[9:0]};
				return result_of({16'h0, HI_SURR_FIRST + {6'h0, adj[19:10]}}, used, ST_CHAR);
			end
			return result_of(cp, used, ST_CHAR);
		endfunction

		function void note_word(mud_in_t w);
			expected_chars.push_back(decode_window(w));
		endfunction

		task check_word(mud_out_t got);
			mud_out_t exp_r;
			if (expected_chars.size() == 0) begin
				report($sformatf("result %h arrived with nothing outstanding", got));
				return;
			end
			exp_r = expected_chars.pop_front();
			checked++;
			if (got.wide_char !== exp_r.wide_char)
				report($sformatf("word %0d wide_char %h, expected %h",
					checked, got.wide_char, exp_r.wide_char));
			if (got.bytes_used !== exp_r.bytes_used)
				report($sformatf("word %0d bytes_used %0d, expected %0d",
					checked, got.bytes_used, exp_r.bytes_used));
			if (got.status !== exp_r.status)
				report($sformatf("word %0d status %0d, expected %0d",
					checked, got.status, exp_r.status));
			if (got.in_initial_state !== exp_r.in_initial_state)
				report($sformatf("word %0d in_initial_state %b, expected %b",
					checked, got.in_initial_state, exp_r.in_initial_state));
			if (exp_r.status <= ST_RESTART)
				status_seen[exp_r.status]++;
		endtask
	endclass

	// --------------------------------------------------------------------
	// clock, channels, block
	// --------------------------------------------------------------------
	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	rx_mode_t              rx_mode = RX_RANDOM;
	logic                  tx_idle = 1'b1;
	int                    cycles = 0;
	int                    settings_run = 0;
	decode_scoreboard      sb = new;

	mud_in_if  in_ch ();
	mud_out_if out_ch ();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multi_encoding_unicode_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (in_ch),
		.dout      (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// run-length guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles, sb.outstanding());
			$display("** multi_encoding_unicode_decoder: FAILED **");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// result side: check accepted words, drive ready
	// --------------------------------------------------------------------
	initial begin
		int hold_count;
		hold_count = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_word(out_ch.data);
			case (rx_mode)
				RX_STEADY: begin
					hold_count = 0;
					out_ch.ready <= 1'b1;
				end
				RX_HOLD: begin
					// long stall counted from the start of the hold phase
					if (hold_count < HOLD_CYCLES) begin
						hold_count++;
						out_ch.ready <= 1'b0;
					end else begin
						out_ch.ready <= ($urandom_range(99) >= 26);
					end
				end
				default: begin
					hold_count = 0;
					out_ch.ready <= ($urandom_range(99) >= 26);
				end
			endcase
		end
	end

	// --------------------------------------------------------------------
	// input side tasks
	// --------------------------------------------------------------------
	function automatic mud_in_t window_of(input logic rs, input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic [2:0] n);
		mud_in_t w;
		w.restart         = rs;
		w.first_byte      = b0;
		w.second_byte     = b1;
		w.third_byte      = b2;
		w.fourth_byte     = b3;
		w.bytes_available = n;
		return w;
	endfunction

	// offer one word, with random idle cycles ahead of it, and wait for accept
	task automatic send_window(input mud_in_t w);
		while (tx_idle && $urandom_range(99) < 26) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= w;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_word(w);
	endtask

	// stop offering and wait until every outstanding result has come back
	task automatic wait_results_done();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.outstanding() != 0);
	endtask

	// both registers, back to back, block idle
	task automatic write_config(input logic [2:0] enc, input logic wide);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ENCODING_SELECT;
		cfg_wdata <= enc;
		@(posedge clk);
		cfg_index <= CFG_WIDE_IS_16BIT;
		cfg_wdata <= {2'b00, wide};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(enc, wide);
		settings_run++;
	endtask

	// random window: mostly well-formed characters, some restarts and noise
	function automatic mud_in_t random_window(input logic [2:0] enc);
		mud_in_t     w;
		logic [7:0]  b [4];
		logic [31:0] cp;
		logic [31:0] adj;
		logic [15:0] hi_u;
		logic [15:0] lo_u;
		int          need;
		int          pick;
		for (int i = 0; i < 4; i++)
			b[i] = 8'($urandom);
		w.restart = 1'b0;
		w.bytes_available = 3'($urandom_range(7));
		pick = $urandom_range(99);
		if (pick < 6) begin
			w.restart = 1'b1;
		end else if (pick >= 22) begin
			case ($urandom_range(4))
				0:       cp = $urandom_range(32'h7F);
				1:       cp = $urandom_range(32'h7FF, 32'h80);
				2:       cp = $urandom_range(32'hFFFF, 32'h800);
				3:       cp = $urandom_range(MAX_CODE, 32'h10000);
				default: cp = $urandom;
			endcase
			case (enc)
				ENC_UTF8: begin
					if (cp > 32'h1FFFFF)
						cp = {11'h0, cp[20:0]};
					if (cp < 32'h80) begin
						b[0] = cp[7:0];
						need = 1;
					end else if (cp < 32'h800) begin
						b[0] = {3'b110, cp[10:6]};
						b[1] = {2'b10, cp[5:0]};
						need = 2;
					end else if (cp < 32'h10000) begin
						b[0] = {4'b1110, cp[15:12]};
						b[1] = {2'b10, cp[11:6]};
						b[2] = {2'b10, cp[5:0]};
						need = 3;
					end else begin
						b[0] = {5'b11110, cp[20:18]};
						b[1] = {2'b10, cp[17:12]};
						b[2] = {2'b10, cp[11:6]};
						b[3] = {2'b10, cp[5:0]};
						need = 4;
					end
				end
				ENC_UTF16_LE, ENC_UTF16_BE: begin
					if (cp > MAX_CODE)
						cp = 32'h10000 + {12'h0, cp[19:0]};
					lo_u = 16'($urandom);
					if (cp >= 32'h10000) begin
						adj  = cp - 32'h10000;
						hi_u = HI_SURR_FIRST + {6'h0, adj[19:10]};
						// now and then a broken pair
						if ($urandom_range(9) != 0)
							lo_u = LO_SURR_FIRST + {6'h0, adj[9:0]};
						need = 4;
					end else begin
						hi_u = cp[15:0];
						need = 2;
					end
					if (enc == ENC_UTF16_BE) begin
						b[0] = hi_u[15:8];
						b[1] = hi_u[7:0];
						b[2] = lo_u[15:8];
						b[3] = lo_u[7:0];
					end else begin
						b[0] = hi_u[7:0];
						b[1] = hi_u[15:8];
						b[2] = lo_u[7:0];
						b[3] = lo_u[15:8];
					end
				end
				ENC_UTF32_LE, ENC_UTF32_BE: begin
					if (enc == ENC_UTF32_BE)
						{b[0], b[1], b[2], b[3]} = cp;
					else
						{b[3], b[2], b[1], b[0]} = cp;
					need = 4;
				end
				default: begin
					b[0] = cp[7:0];
					need = 1;
				end
			endcase
			// mostly the exact count, sometimes short or oversized
			if ($urandom_range(9) < 8)
				w.bytes_available = 3'(need);
		end
		w.first_byte  = b[0];
		w.second_byte = b[1];
		w.third_byte  = b[2];
		w.fourth_byte = b[3];
		return w;
	endfunction

	// --------------------------------------------------------------------
	// stimulus
	// --------------------------------------------------------------------
	initial begin
		int phase;
		in_ch.valid = 1'b0;
		in_ch.data  = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_wdata   = '0;
		arst_n      = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// utf-8 at reset settings: restart, short windows, each lead class
		send_window(window_of(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7));
		send_window(window_of(1'b0, 8'h41, 8'h00, 8'h00, 8'h00, 3'd0));
		send_window(window_of(1'b0, 8'h00, 8'h41, 8'h41, 8'h41, 3'd1));
		send_window(window_of(1'b0, 8'h7F, 8'h00, 8'h00, 8'h00, 3'd1));
		send_window(window_of(1'b0, 8'hC3, 8'hA9, 8'h00, 8'h00, 3'd1));
		send_window(window_of(1'b0, 8'hC3, 8'hA9, 8'h00, 8'h00, 3'd2));
		send_window(window_of(1'b0, 8'hE2, 8'h82, 8'hAC, 8'h00, 3'd3));
		send_window(window_of(1'b0, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd7));
		send_window(window_of(1'b0, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd4));
		send_window(window_of(1'b0, 8'h80, 8'h80, 8'h80, 8'h80, 3'd4));
		send_window(window_of(1'b0, 8'hFF, 8'h80, 8'h80, 8'h80, 3'd4));
		wait_results_done();

		// utf-16 big endian, split mode: pairs, held half, restart, broken pair
		write_config(ENC_UTF16_BE, 1'b1);
		send_window(window_of(1'b0, 8'hD8, 8'h3D, 8'hDE, 8'h00, 3'd4));
		send_window(window_of(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0));
		send_window(window_of(1'b0, 8'hD8, 8'h3D, 8'hDE, 8'h00, 3'd4));
		send_window(window_of(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0));
		send_window(window_of(1'b0, 8'hD8, 8'h3D, 8'h00, 8'h41, 3'd4));
		send_window(window_of(1'b0, 8'hDC, 8'h00, 8'h00, 8'h00, 3'd2));
		send_window(window_of(1'b0, 8'hD8, 8'h00, 8'hDC, 8'h00, 3'd3));
		send_window(window_of(1'b0, 8'h00, 8'h00, 8'h41, 8'h41, 3'd2));
		send_window(window_of(1'b0, 8'h41, 8'h00, 8'h00, 8'h00, 3'd1));
		wait_results_done();

		// utf-32 little endian, split mode: beyond the last code point, a pair
		write_config(ENC_UTF32_LE, 1'b1);
		send_window(window_of(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4));
		send_window(window_of(1'b0, 8'h00, 8'h00, 8'h10, 8'h00, 3'd4));
		send_window(window_of(1'b0, 8'h41, 8'h41, 8'h41, 8'h41, 3'd4));
		send_window(window_of(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 3'd4));
		send_window(window_of(1'b0, 8'h41, 8'h00, 8'h00, 8'h00, 3'd3));
		wait_results_done();

		// spare selector code behaves as extended ascii
		write_config(ENC_SPARE, 1'b0);
		send_window(window_of(1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 3'd1));
		send_window(window_of(1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd4));
		wait_results_done();

		// random phases over every selector code and both wide modes
		for (int e = 0; e < 8; e++) begin
			for (int wd = 0; wd < 2; wd++) begin
				phase = e * 2 + wd;
				write_config(3'(e), 1'(wd));
				// one phase without idling, one with a long output stall
				if (phase == 5) begin
					tx_idle <= 1'b0;
					rx_mode <= RX_STEADY;
				end else if (phase == 9) begin
					rx_mode <= RX_HOLD;
				end
				for (int i = 0; i < PHASE_WORDS; i++) begin
					send_window(random_window(3'(e)));
					// input pause until the pipeline has drained
					if (phase == 12 && i == PHASE_WORDS / 2)
						wait_results_done();
				end
				wait_results_done();
				tx_idle <= 1'b1;
				rx_mode <= RX_RANDOM;
			end
		end

		// let any stray result show up
		repeat (6) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.report($sformatf("%0d results never arrived", sb.outstanding()));

		$display("checked %0d result words across %0d register settings, %0d mismatches",
			sb.checked, settings_run, sb.errors);
		$display("statuses: char %0d, terminator %0d, incomplete %0d, illegal %0d, restart %0d",
			sb.status_seen[ST_CHAR], sb.status_seen[ST_TERM], sb.status_seen[ST_INCOMPLETE],
			sb.status_seen[ST_ILLEGAL], sb.status_seen[ST_RESTART]);
		if (sb.errors == 0) begin
			$display("** multi_encoding_unicode_decoder: PASSED **");
		end else begin
			$display("** multi_encoding_unicode_decoder: FAILED **");
		end
		$finish;
	end

endmodule
